/* hw/rtl/trs_pkg.sv */
// Shared widths, fixed-point constants and register codes for the point transform.
package trs_pkg;

  // Fixed-point formats of the operands.
  localparam int COORD_W = 32;  // Q16.16 coordinates
  localparam int SCALE_W = 16;  // Q8.8 scales
  localparam int ROT_W   = 16;  // Q2.14 quaternion components
  localparam int SBITS   = 8;   // fraction bits of a scale
  localparam int QBITS   = 14;  // fraction bits of a quaternion component

  // Intermediate widths along the datapath.
  localparam int PROD_W = COORD_W + SCALE_W;   // coordinate times scale
  localparam int P_W    = PROD_W - SBITS + 1;  // scaled coordinate after rounding
  localparam int C_W    = ROT_W + P_W + 1;     // first cross product
  localparam int T_W    = C_W - QBITS;         // rounded first cross product
  localparam int U_W    = ROT_W + T_W + 1;     // second cross product
  localparam int WT_W   = ROT_W + T_W;         // w times rounded cross product
  localparam int ACC_W  = 64;                  // rotation accumulator
  localparam int R_W    = ACC_W - QBITS;       // rotated coordinate after rounding
  localparam int RP_W   = R_W + 1;             // rotated plus translation

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 3 * SCALE_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POS_X     = 4'd0,
    REG_POS_Y     = 4'd1,
    REG_POS_Z     = 4'd2,
    REG_ROT_X     = 4'd3,
    REG_ROT_Y     = 4'd4,
    REG_ROT_Z     = 4'd5,
    REG_ROT_W     = 4'd6,
    REG_SCALE_XYZ = 4'd7
  } cfg_reg_t;

  // Command codes.
  localparam logic CMD_POINT  = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  // Reset values: identity rotation and unit scale.
  localparam logic signed [ROT_W-1:0]   ROT_ONE   = 16'sd16384;
  localparam logic signed [SCALE_W-1:0] SCALE_ONE = 16'sd256;

endpackage

/* hw/rtl/trs_point_transform.sv */
// Top level of the scale, quaternion-rotate and translate point transform.
//
// Usage: pulse start with a coordinate (in_x, in_y, in_z, signed Q16.16) and
// in_cmd (point or direction vector). The block never pushes back, so busy is
// always low and a beat can be started in every cycle.
// Each beat is scaled per axis, rotated by the configured quaternion with
// v + 2w(q x v) + 2 q x (q x v), translated when it is a point, then rounded
// and saturated to Q16.16. out_saturated reports any clamped component.
// Result: out_valid rises together with the registered, saturated result and
// is high for a single cycle per beat, so the result is taken while it is high.
// Throughput: one beat per cycle, set by the nine-stage pipeline, which never
// stalls and gives every multiplication its own multiplier.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_addr in
// the same edge; indexes beyond the register list are ignored. Write only
// while no beat is in flight.
// Reset: clears all valid bits and loads zero translation, the identity
// quaternion and unit scale on every axis.
// The receiver cannot stall: each result is presented for exactly one cycle.
module trs_point_transform
  import trs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // Input channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic signed [COORD_W-1:0]    in_x,
  input  logic signed [COORD_W-1:0]    in_y,
  input  logic signed [COORD_W-1:0]    in_z,
  // Result channel
  output logic                         out_valid,
  output logic signed [COORD_W-1:0]    out_x,
  output logic signed [COORD_W-1:0]    out_y,
  output logic signed [COORD_W-1:0]    out_z,
  output logic                         out_saturated
);

  typedef struct packed {
    logic                  cmd;
    logic signed [P_W-1:0] p_x;
    logic signed [P_W-1:0] p_y;
    logic signed [P_W-1:0] p_z;
  } side_t;

  localparam int SIDE_N = 5;

  // Configuration registers.
  logic signed [COORD_W-1:0] pos_r [3];
  logic signed [ROT_W-1:0]   rot_r [4];
  logic [CFG_DATA_W-1:0]     scale_r;

  logic signed [COORD_W-1:0] coord [3];
  logic signed [SCALE_W-1:0] scale [3];
  logic signed [ROT_W-1:0]   rot_v [3];

  // Scale stage outputs.
  logic                      s2_valid;
  logic                      s2_cmd;
  logic signed [P_W-1:0]     s2_p [3];

  // First cross product and its rounding.
  logic                      c_valid;
  logic signed [C_W-1:0]     c_d [3];
  logic signed [C_W:0]       tsum [3];
  logic signed [T_W-1:0]     t_nxt [3];
  logic signed [T_W-1:0]     t_r [3];
  logic                      v5_r;

  // Second cross product and the w term.
  logic                      u_valid;
  logic signed [U_W-1:0]     u_d [3];
  logic signed [WT_W-1:0]    wt_nxt [3];
  logic signed [WT_W-1:0]    wt1_r [3];
  logic signed [WT_W-1:0]    wt2_r [3];

  // Sideband carried alongside the cross products.
  side_t                     side_r [SIDE_N];
  logic signed [P_W-1:0]     pd [3];

  // Accumulate, round and translate.
  logic signed [ACC_W-1:0]   acc [3];
  logic signed [R_W-1:0]     rr [3];
  logic signed [RP_W-1:0]    rp_nxt [3];
  logic signed [RP_W-1:0]    rp_r [3];
  logic                      v8_r;

  // Saturation.
  logic signed [COORD_W-1:0] sat_val [3];
  logic [2:0]                sat_hit;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_r [3];
  logic                      out_sat_r;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        rot_r[i] <= '0;
      end
      rot_r[3] <= ROT_ONE;
      scale_r  <= {SCALE_ONE, SCALE_ONE, SCALE_ONE};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_POS_X:     pos_r[0] <= cfg_wdata[COORD_W-1:0];
        REG_POS_Y:     pos_r[1] <= cfg_wdata[COORD_W-1:0];
        REG_POS_Z:     pos_r[2] <= cfg_wdata[COORD_W-1:0];
        REG_ROT_X:     rot_r[0] <= cfg_wdata[ROT_W-1:0];
        REG_ROT_Y:     rot_r[1] <= cfg_wdata[ROT_W-1:0];
        REG_ROT_Z:     rot_r[2] <= cfg_wdata[ROT_W-1:0];
        REG_ROT_W:     rot_r[3] <= cfg_wdata[ROT_W-1:0];
        REG_SCALE_XYZ: scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a beat is taken whenever start is high.
  assign busy = 1'b0;

  assign coord[0] = in_x;
  assign coord[1] = in_y;
  assign coord[2] = in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scale[i] = scale_r[i*SCALE_W +: SCALE_W];
      rot_v[i] = rot_r[i];
    end
  end

  // Stages 1 and 2: per-axis scaling.
  trs_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start),
    .cmd_i   (in_cmd),
    .coord_i (coord),
    .scale_i (scale),
    .valid_o (s2_valid),
    .cmd_o   (s2_cmd),
    .p_o     (s2_p)
  );

  // Stages 3 and 4: q x p.
  trs_cross #(.AW(P_W)) u_cross_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .rot_i   (rot_v),
    .a_i     (s2_p),
    .valid_o (c_valid),
    .d_o     (c_d)
  );

  // Stage 5: round the first cross product to t.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i]  = (C_W + 1)'(c_d[i]) + (C_W + 1)'(1 << (QBITS - 1));
      t_nxt[i] = tsum[i][QBITS +: T_W];
    end
  end

  // Stages 6 and 7: q x t.
  trs_cross #(.AW(T_W)) u_cross_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v5_r),
    .rot_i   (rot_v),
    .a_i     (t_r),
    .valid_o (u_valid),
    .d_o     (u_d)
  );

  // Stage 6 also forms w * t, delayed one more stage to line up with q x t.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wt_nxt[i] = WT_W'(rot_r[3]) * WT_W'(t_r[i]);
    end
  end

  // Scaled coordinate as seen at the accumulate stage.
  assign pd[0] = side_r[SIDE_N-1].p_x;
  assign pd[1] = side_r[SIDE_N-1].p_y;
  assign pd[2] = side_r[SIDE_N-1].p_z;

  // Stage 8: p * 2^14 + 2wt + 2u, rounded, plus translation for a point.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (ACC_W'(pd[i]) <<< QBITS) + (ACC_W'(wt2_r[i]) <<< 1)
             + (ACC_W'(u_d[i]) <<< 1) + ACC_W'(1 << (QBITS - 1));
      rr[i]  = acc[i][QBITS +: R_W];
      if (side_r[SIDE_N-1].cmd == CMD_VECTOR) begin
        rp_nxt[i] = RP_W'(rr[i]);
      end else begin
        rp_nxt[i] = RP_W'(rr[i]) + RP_W'(pos_r[i]);
      end
    end
  end

  // Stage 9: clamp to the Q16.16 range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_hit[i] = (rp_r[i][RP_W-1:COORD_W-1] != {(RP_W - COORD_W + 1){rp_r[i][RP_W-1]}});
      if (!sat_hit[i]) begin
        sat_val[i] = rp_r[i][COORD_W-1:0];
      end else if (rp_r[i][RP_W-1]) begin
        sat_val[i] = {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
        sat_val[i] = {1'b0, {(COORD_W - 1){1'b1}}};
      end
    end
  end

  // Valid bits owned by the top level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v5_r        <= c_valid;
      v8_r        <= u_valid;
      out_valid_r <= v8_r;
    end
  end

  // Data registers and the sideband shift line.
  always_ff @(posedge clk) begin
    side_r[0] <= '{cmd: s2_cmd, p_x: s2_p[0], p_y: s2_p[1], p_z: s2_p[2]};
    for (int k = 1; k < SIDE_N; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      t_r[i]   <= t_nxt[i];
      wt1_r[i] <= wt_nxt[i];
      wt2_r[i] <= wt1_r[i];
      rp_r[i]  <= rp_nxt[i];
      out_r[i] <= sat_val[i];
    end
    out_sat_r <= |sat_hit;
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_r[0];
  assign out_y         = out_r[1];
  assign out_z         = out_r[2];
  assign out_saturated = out_sat_r;

endmodule

/* hw/rtl/trs_scale.sv */
// Per-axis scaling stage: coordinate times Q8.8 scale, rounded to Q25.16.
module trs_scale
  import trs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  logic                      cmd_i,
  input  logic signed [COORD_W-1:0] coord_i [3],
  input  logic signed [SCALE_W-1:0] scale_i [3],
  output logic                      valid_o,
  output logic                      cmd_o,
  output logic signed [P_W-1:0]     p_o [3]
);

  logic                      v1_r;
  logic                      cmd1_r;
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [PROD_W-1:0]  prod_nxt [3];
  logic                      v2_r;
  logic                      cmd2_r;
  logic signed [P_W-1:0]     p_r [3];
  logic signed [P_W-1:0]     p_nxt [3];
  logic signed [PROD_W:0]    rsum [3];

  // First stage: one multiplier per axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PROD_W'(coord_i[i]) * PROD_W'(scale_i[i]);
    end
  end

  // Second stage: add half an LSB and drop the scale fraction bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i]  = (PROD_W + 1)'(prod_r[i]) + (PROD_W + 1)'(1 << (SBITS - 1));
      p_nxt[i] = rsum[i][SBITS +: P_W];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    cmd1_r <= cmd_i;
    cmd2_r <= cmd1_r;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= prod_nxt[i];
      p_r[i]    <= p_nxt[i];
    end
  end

  assign valid_o = v2_r;
  assign cmd_o   = cmd2_r;
  assign p_o     = p_r;

endmodule

/* hw/rtl/trs_cross.sv */
// Two-stage cross product of the quaternion vector part with a 3D operand.
module trs_cross
  import trs_pkg::*;
#(
  parameter int AW = 41
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  logic signed [ROT_W-1:0]   rot_i [3],
  input  logic signed [AW-1:0]      a_i [3],
  output logic                      valid_o,
  output logic signed [ROT_W+AW:0]  d_o [3]
);

  localparam int MW = ROT_W + AW;
  localparam int DW = MW + 1;

  logic                  v1_r;
  logic                  v2_r;
  logic signed [MW-1:0]  m_r [6];
  logic signed [MW-1:0]  m_nxt [6];
  logic signed [DW-1:0]  d_r [3];
  logic signed [DW-1:0]  d_nxt [3];

  // Product stage: the six partial products, two per output lane.
  always_comb begin
    m_nxt[0] = MW'(rot_i[1]) * MW'(a_i[2]);
    m_nxt[1] = MW'(rot_i[2]) * MW'(a_i[1]);
    m_nxt[2] = MW'(rot_i[2]) * MW'(a_i[0]);
    m_nxt[3] = MW'(rot_i[0]) * MW'(a_i[2]);
    m_nxt[4] = MW'(rot_i[0]) * MW'(a_i[1]);
    m_nxt[5] = MW'(rot_i[1]) * MW'(a_i[0]);
  end

  // Difference stage.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'(m_r[2*i]) - DW'(m_r[2*i+1]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      m_r[i] <= m_nxt[i];
    end
    for (int i = 0; i < 3; i++) begin
      d_r[i] <= d_nxt[i];
    end
  end

  assign valid_o = v2_r;
  assign d_o     = d_r;

endmodule
